/* rtl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int POS_W = 7;
    localparam int VAL_W = 32;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_FIND   = 3'd2;
    localparam logic [2:0] ACT_COUNT  = 3'd3;
    localparam logic [2:0] ACT_DEDUPE = 3'd4;
    localparam logic [2:0] ACT_DELRNG = 3'd5;
    localparam logic [2:0] ACT_DUMP   = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_DRD,
        S_DEX,
        S_INSW
    } t_state;

endpackage

/* rtl/sle_ram.sv */
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sequential_list_engine.sv */
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit values in one RAM, with insert, delete,
// find, range count, dedupe, range delete and dump commands.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  command   start / busy        i_action, i_position, i_value, i_range_high
//  result    o_valid (1 cycle)   o_result_value, o_status, o_last
//
//  a command walks the list one element at a time (RAM read, then act on the
//  registered data); dedupe also compares each element against the kept
//  prefix in an inner loop. errors and empty lists answer at once.
//  busy stays high until the last result is loaded. synchronous reset
//  clears length and control; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_action,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic signed [VAL_W-1:0] i_range_high,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_result_value,
    output logic [1:0]              o_status,
    output logic                    o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

    t_state r_state, n_state;

    logic [POS_W-1:0]        r_len, n_len;
    logic [POS_W-1:0]        r_i, n_i;
    logic [POS_W-1:0]        r_j, n_j;
    logic [POS_W-1:0]        r_k, n_k;
    logic [POS_W-1:0]        r_cnt, n_cnt;
    logic [2:0]              r_act, n_act;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic signed [VAL_W-1:0] r_hi, n_hi;
    logic signed [VAL_W-1:0] r_cur, n_cur;
    logic                    r_valid, n_valid;
    logic signed [VAL_W-1:0] r_res, n_res;
    logic [1:0]              r_status, n_status;
    logic                    r_last, n_last;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [VAL_W-1:0] wdata, rdata;

    logic             acc, full, ins_bad, del_bad, inr, last_i, seen, hit;
    logic [POS_W-1:0] i_inc, i_dec;

    sle_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign acc     = start && (r_state == S_IDLE);
    assign full    = r_len >= CAP;
    assign ins_bad = (i_position == '0) || (i_position > r_len + POS_W'(1));
    assign del_bad = (i_position == '0) || (i_position > r_len);
    assign inr     = ($signed(rdata) >= r_val) && ($signed(rdata) <= r_hi);
    assign i_inc   = r_i + POS_W'(1);
    assign i_dec   = r_i - POS_W'(1);
    assign last_i  = i_inc == r_len;
    assign seen    = rdata == r_cur;
    assign hit     = rdata == r_val;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    priority case (i_action)
                        ACT_INSERT: begin
                            if (full || ins_bad) n_state = S_IDLE;
                            else if (r_len >= i_position) n_state = S_RD;
                            else n_state = S_INSW;
                        end
                        ACT_DELETE: begin
                            if (!del_bad && (i_position < r_len)) n_state = S_RD;
                        end
                        ACT_FIND, ACT_COUNT, ACT_DEDUPE, ACT_DELRNG, ACT_DUMP: begin
                            if (r_len != '0) n_state = S_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: n_state = S_EX;
            S_EX: begin
                priority case (r_act)
                    ACT_INSERT: n_state = (i_dec >= r_pos) ? S_RD : S_INSW;
                    ACT_DELETE: n_state = (r_i + POS_W'(2) < r_len) ? S_RD : S_IDLE;
                    ACT_FIND:   n_state = (hit || last_i) ? S_IDLE : S_RD;
                    ACT_DEDUPE: begin
                        if (r_k != '0) n_state = S_DRD;
                        else n_state = last_i ? S_IDLE : S_RD;
                    end
                    default:    n_state = last_i ? S_IDLE : S_RD;
                endcase
            end
            S_DRD: n_state = S_DEX;
            S_DEX: begin
                if (rdata == r_cur || (r_j + POS_W'(1) == r_k)) begin
                    n_state = last_i ? S_IDLE : S_RD;
                end else begin
                    n_state = S_DRD;
                end
            end
            S_INSW: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory access and results
    always_comb begin
        n_len    = r_len;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_act    = r_act;
        n_pos    = r_pos;
        n_val    = r_val;
        n_hi     = r_hi;
        n_cur    = r_cur;
        n_valid  = 1'b0;
        n_res    = '0;
        n_status = ST_OK;
        n_last   = 1'b1;
        we       = 1'b0;
        waddr    = r_i[AW-1:0];
        wdata    = rdata;
        raddr    = r_i[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_act = i_action;
                    n_pos = i_position;
                    n_val = i_value;
                    n_hi  = i_range_high;
                    n_cnt = '0;
                    n_k   = '0;
                    n_j   = '0;
                    n_i   = '0;
                    priority case (i_action)
                        ACT_INSERT: begin
                            n_i = r_len;
                            if (full) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end else if (ins_bad) begin
                                n_valid  = 1'b1;
                                n_status = ST_BADPOS;
                            end
                        end
                        ACT_DELETE: begin
                            n_i = i_position - POS_W'(1);
                            if (del_bad) begin
                                n_valid  = 1'b1;
                                n_status = ST_BADPOS;
                            end else if (!(i_position < r_len)) begin
                                n_len   = r_len - POS_W'(1);
                                n_valid = 1'b1;
                            end
                        end
                        ACT_FIND, ACT_COUNT, ACT_DEDUPE, ACT_DELRNG: begin
                            n_valid = r_len == '0;
                        end
                        ACT_DUMP: begin
                            if (r_len == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            S_RD: begin
                if (r_act == ACT_INSERT) raddr = i_dec[AW-1:0];
                else if (r_act == ACT_DELETE) raddr = i_inc[AW-1:0];
            end
            S_EX: begin
                priority case (r_act)
                    ACT_INSERT: begin
                        we  = 1'b1;
                        n_i = i_dec;
                    end
                    ACT_DELETE: begin
                        we  = 1'b1;
                        n_i = i_inc;
                        if (!(r_i + POS_W'(2) < r_len)) begin
                            n_len   = r_len - POS_W'(1);
                            n_valid = 1'b1;
                        end
                    end
                    ACT_FIND: begin
                        n_i = i_inc;
                        if (hit) begin
                            n_valid = 1'b1;
                            n_res   = VAL_W'(i_inc);
                        end else if (last_i) begin
                            n_valid = 1'b1;
                        end
                    end
                    ACT_COUNT: begin
                        n_i   = i_inc;
                        n_cnt = r_cnt + POS_W'(inr);
                        if (last_i) begin
                            n_valid = 1'b1;
                            n_res   = VAL_W'(n_cnt);
                        end
                    end
                    ACT_DELRNG: begin
                        n_i = i_inc;
                        if (!inr) begin
                            we    = 1'b1;
                            waddr = r_k[AW-1:0];
                            n_k   = r_k + POS_W'(1);
                        end
                        if (last_i) begin
                            n_len   = n_k;
                            n_valid = 1'b1;
                        end
                    end
                    ACT_DUMP: begin
                        n_i     = i_inc;
                        n_valid = 1'b1;
                        n_res   = rdata;
                        n_last  = last_i;
                    end
                    default: begin
                        // dedupe: hold the candidate, then scan the kept prefix
                        n_cur = rdata;
                        n_j   = '0;
                        if (r_k == '0) begin
                            we    = 1'b1;
                            waddr = '0;
                            n_k   = POS_W'(1);
                            n_i   = i_inc;
                            if (last_i) begin
                                n_len   = POS_W'(1);
                                n_valid = 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_DRD: raddr = r_j[AW-1:0];
            S_DEX: begin
                if (seen) begin
                    n_i = i_inc;
                    if (last_i) begin
                        n_len   = r_k;
                        n_valid = 1'b1;
                    end
                end else if (r_j + POS_W'(1) == r_k) begin
                    we    = 1'b1;
                    waddr = r_k[AW-1:0];
                    wdata = r_cur;
                    n_k   = r_k + POS_W'(1);
                    n_i   = i_inc;
                    if (last_i) begin
                        n_len   = n_k;
                        n_valid = 1'b1;
                    end
                end else begin
                    n_j = r_j + POS_W'(1);
                end
            end
            S_INSW: begin
                we      = 1'b1;
                waddr   = AW'(r_pos - POS_W'(1));
                wdata   = r_val;
                n_len   = r_len + POS_W'(1);
                n_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_valid <= n_valid;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_act    <= n_act;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_hi     <= n_hi;
        r_cur    <= n_cur;
        r_res    <= n_res;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign busy           = r_state != S_IDLE;
    assign o_valid        = r_valid;
    assign o_result_value = r_res;
    assign o_status       = r_status;
    assign o_last         = r_last;

endmodule
